@@ hdl/mrc_pkg.sv @@
// ----------------------------------------------------------------------------
// mrc_pkg
// Shared types, character constants and the tag table for the modem
// response classifier.
// ----------------------------------------------------------------------------
package mrc_pkg;

    localparam int MAX_BYTES_DEF = 128;

    // Result codes
    typedef enum logic [2:0] {
        RES_EMPTY    = 3'd0,
        RES_OK       = 3'd1,
        RES_SENT     = 3'd2,
        RES_NOT_SENT = 3'd3,
        RES_ERROR    = 3'd4
    } t_result_code;

    // Number parser phase
    typedef enum logic [1:0] {
        NUM_SKIP   = 2'd0,
        NUM_DIGITS = 2'd1,
        NUM_DONE   = 2'd2
    } t_num_phase;

    // Characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_O     = 8'h4F;
    localparam logic [7:0] CH_K     = 8'h4B;

    localparam logic [2:0] TAG_LEN = 3'd7;
    localparam logic [1:0] TOK_MAX = 2'd3;
    localparam logic [1:0] TOK_NUM = 2'd2;

    // Per-response scan state (byte counter lives in the scanner)
    typedef struct packed {
        logic        text_ended;
        logic        starts_with_cr;
        logic [1:0]  ok_prog;
        logic        ok_seen;
        logic [2:0]  tag_prog;
        logic        tag_seen;
        logic [1:0]  token_index;
        logic        inside_token;
        t_num_phase  num_phase;
        logic        num_negative;
        logic [15:0] num_value;
    } t_scan_state;

    // "+SBDIX:" by position
    function automatic logic [7:0] tag_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h2B; // +
            3'd1:    c = 8'h53; // S
            3'd2:    c = 8'h42; // B
            3'd3:    c = 8'h44; // D
            3'd4:    c = 8'h49; // I
            3'd5:    c = 8'h58; // X
            3'd6:    c = 8'h3A; // :
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

@@ hdl/mrc_scan.sv @@
// ----------------------------------------------------------------------------
// mrc_scan
// Per-byte scanner: pattern matchers, tokenizer and number accumulator.
// ----------------------------------------------------------------------------
module mrc_scan #(
    parameter int MAX_BYTES = mrc_pkg::MAX_BYTES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_advance,
    input  logic [7:0]           i_rx_byte,
    input  logic                 i_last_byte,
    output mrc_pkg::t_scan_state o_next
);

    localparam int POS_W = $clog2(MAX_BYTES + 1);
    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_BYTES);

    mrc_pkg::t_scan_state r_st, n_st;
    logic [POS_W-1:0]     r_pos, n_pos;
    logic                 w_digit, w_space, w_sep;
    logic [15:0]          w_dval;
    logic [1:0]           w_tok;

    assign w_digit = (i_rx_byte >= mrc_pkg::CH_ZERO) && (i_rx_byte <= mrc_pkg::CH_NINE);
    assign w_dval  = {12'd0, i_rx_byte[3:0]};
    assign w_space = (i_rx_byte == mrc_pkg::CH_SPACE) || (i_rx_byte == mrc_pkg::CH_TAB) ||
                     (i_rx_byte == mrc_pkg::CH_LF)    || (i_rx_byte == mrc_pkg::CH_VT)  ||
                     (i_rx_byte == mrc_pkg::CH_FF)    || (i_rx_byte == mrc_pkg::CH_CR);
    assign w_sep   = (i_rx_byte == mrc_pkg::CH_SPACE) || (i_rx_byte == mrc_pkg::CH_COMMA);

    always_comb begin
        n_st  = r_st;
        n_pos = r_pos;
        w_tok = r_st.token_index;
        if (!r_st.text_ended && (r_pos < POS_LIMIT)) begin
            if (i_rx_byte == mrc_pkg::CH_NUL) begin
                n_st.text_ended = 1'b1;
            end else begin
                if ((r_pos == '0) && (i_rx_byte == mrc_pkg::CH_CR)) begin
                    n_st.starts_with_cr = 1'b1;
                end
                n_pos = r_pos + POS_W'(1);

                // "OK\r"
                if ((r_st.ok_prog == 2'd2) && (i_rx_byte == mrc_pkg::CH_CR)) begin
                    n_st.ok_seen = 1'b1;
                    n_st.ok_prog = 2'd0;
                end else if (i_rx_byte == mrc_pkg::CH_O) begin
                    n_st.ok_prog = 2'd1;
                end else if ((r_st.ok_prog == 2'd1) && (i_rx_byte == mrc_pkg::CH_K)) begin
                    n_st.ok_prog = 2'd2;
                end else begin
                    n_st.ok_prog = 2'd0;
                end

                // "+SBDIX:" (all characters distinct, no overlap handling)
                if ((r_st.tag_prog < mrc_pkg::TAG_LEN) &&
                    (i_rx_byte == mrc_pkg::tag_char(r_st.tag_prog))) begin
                    if (r_st.tag_prog == mrc_pkg::TAG_LEN - 3'd1) begin
                        n_st.tag_seen = 1'b1;
                        n_st.tag_prog = 3'd0;
                    end else begin
                        n_st.tag_prog = r_st.tag_prog + 3'd1;
                    end
                end else begin
                    n_st.tag_prog = (i_rx_byte == mrc_pkg::CH_PLUS) ? 3'd1 : 3'd0;
                end

                // tokenizer + number on the second token
                if (w_sep) begin
                    n_st.inside_token = 1'b0;
                end else begin
                    if (!r_st.inside_token) begin
                        n_st.inside_token = 1'b1;
                        if (r_st.token_index != mrc_pkg::TOK_MAX) begin
                            w_tok = r_st.token_index + 2'd1;
                        end
                    end
                    n_st.token_index = w_tok;
                    if (w_tok == mrc_pkg::TOK_NUM) begin
                        unique case (r_st.num_phase)
                            mrc_pkg::NUM_SKIP: begin
                                if (w_space) begin
                                    n_st.num_phase = mrc_pkg::NUM_SKIP;
                                end else if ((i_rx_byte == mrc_pkg::CH_PLUS) ||
                                             (i_rx_byte == mrc_pkg::CH_MINUS)) begin
                                    n_st.num_negative = (i_rx_byte == mrc_pkg::CH_MINUS);
                                    n_st.num_phase    = mrc_pkg::NUM_DIGITS;
                                end else if (w_digit) begin
                                    n_st.num_value = w_dval;
                                    n_st.num_phase = mrc_pkg::NUM_DIGITS;
                                end else begin
                                    n_st.num_phase = mrc_pkg::NUM_DONE;
                                end
                            end
                            mrc_pkg::NUM_DIGITS: begin
                                if (w_digit) begin
                                    // value * 10 + digit, mod 2^16
                                    n_st.num_value = (r_st.num_value << 3) +
                                                     (r_st.num_value << 1) + w_dval;
                                end else begin
                                    n_st.num_phase = mrc_pkg::NUM_DONE;
                                end
                            end
                            default: begin
                                n_st.num_phase = r_st.num_phase;
                            end
                        endcase
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= '0;
            r_pos <= '0;
        end else if (i_advance) begin
            if (i_last_byte) begin
                r_st  <= '0;
                r_pos <= '0;
            end else begin
                r_st  <= n_st;
                r_pos <= n_pos;
            end
        end
    end

    assign o_next = n_st;

endmodule

@@ hdl/mrc_classify.sv @@
// ----------------------------------------------------------------------------
// mrc_classify
// Maps the scan state after the final byte to a result code.
// ----------------------------------------------------------------------------
module mrc_classify (
    input  mrc_pkg::t_scan_state  i_state,
    output mrc_pkg::t_result_code o_code
);

    logic [15:0] w_value;

    assign w_value = i_state.num_negative ? (16'd0 - i_state.num_value) : i_state.num_value;

    always_comb begin
        priority if (i_state.starts_with_cr) begin
            o_code = mrc_pkg::RES_EMPTY;
        end else if (i_state.ok_seen) begin
            o_code = mrc_pkg::RES_OK;
        end else if (i_state.tag_seen) begin
            if (i_state.token_index < mrc_pkg::TOK_NUM) begin
                o_code = mrc_pkg::RES_NOT_SENT;
            end else if (w_value <= 16'd2) begin
                o_code = mrc_pkg::RES_SENT;
            end else begin
                o_code = mrc_pkg::RES_NOT_SENT;
            end
        end else begin
            o_code = mrc_pkg::RES_ERROR;
        end
    end

endmodule

@@ hdl/modem_response_classifier.sv @@
// ----------------------------------------------------------------------------
// modem_response_classifier
// Classifies a modem response byte stream into empty / ok / sent /
// not sent / error, one result per response on its final byte.
// ----------------------------------------------------------------------------
// The final byte is held in the input register, then its code is loaded
// into the result register, which drives o_out_valid.
// Throughput: one byte per cycle, except for the final-byte stall below.
// A pending result does not block non-final bytes; a final byte waits in
// the input register only while the previous result is still not taken.
// Reset: synchronous active-low i_rst_n clears all scan state and valids.
// ----------------------------------------------------------------------------
module modem_response_classifier #(
    parameter int MAX_BYTES = mrc_pkg::MAX_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // byte request channel
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_rx_byte,
    input  logic       i_last_byte,
    // result request channel
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [2:0] o_result_code
);

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // result register
    logic                  r_out_valid;
    mrc_pkg::t_result_code r_out_code;

    logic                  w_advance;
    mrc_pkg::t_scan_state  w_next;
    mrc_pkg::t_result_code w_code;

    // The held byte moves on unless it is a final byte and the result
    // register is still occupied by an untaken result.
    assign w_advance  = r_in_valid && (!r_in_last || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_rx_byte;
            r_in_last <= i_last_byte;
        end
    end

    mrc_scan #(
        .MAX_BYTES (MAX_BYTES)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (w_advance),
        .i_rx_byte   (r_in_byte),
        .i_last_byte (r_in_last),
        .o_next      (w_next)
    );

    mrc_classify u_classify (
        .i_state (w_next),
        .o_code  (w_code)
    );

    // result register: loads on a final byte, clears when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && r_in_last) begin
            r_out_code <= w_code;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_result_code = r_out_code;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_nonlast_flows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !r_in_last) |-> w_advance)
        else $error("non-final byte stalled in input register");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !(w_advance && r_in_last))
        else $error("pending result overwritten");

    a_final_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_in_last) |=> o_out_valid)
        else $error("final byte produced no result");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for modem_response_classifier. Responses are streamed
// a byte at a time over the byte request channel; an in-bench scanner
// tracks the same matchers and number parser and queues the expected code
// on each final byte. Every result request is checked against that queue.
// ----------------------------------------------------------------------------
module tb;

    localparam int    LIMIT_BYTES = mrc_pkg::MAX_BYTES_DEF;
    localparam int    CYCLE_LIMIT = 400000;
    localparam string TAG_TEXT    = "+SBDIX:";

    // ------------------------------------------------------------------------
    // Clock, reset and DUT ports. Every input has a known value at time 0.
    // ------------------------------------------------------------------------
    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_in_valid    = 1'b0;
    logic [7:0] i_rx_byte     = 8'h00;
    logic       i_last_byte   = 1'b0;
    logic       i_out_ready   = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [2:0] o_result_code;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    modem_response_classifier #(
        .MAX_BYTES(LIMIT_BYTES)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_rx_byte    (i_rx_byte),
        .i_last_byte  (i_last_byte),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_result_code(o_result_code)
    );

    // ------------------------------------------------------------------------
    // Scanner state mirrored in the bench. Cleared after each final byte.
    // ------------------------------------------------------------------------
    mrc_pkg::t_scan_state  scan;
    logic [7:0]            scan_pos;
    mrc_pkg::t_result_code pending_codes[$];   // expected code per response in flight
    mrc_pkg::t_result_code want_code;

    int err_count      = 0;
    int results_seen   = 0;
    int responses_sent = 0;
    int bytes_sent     = 0;
    int scanned_count  = 0;           // bytes that actually moved the scanner
    int code_tally[5]  = '{default: 0};
    int cycle_count    = 0;

    // Knobs shared between the stimulus and the result-side process
    bit in_burst     = 1'b0;          // sender: no gaps while set
    bit rx_burst     = 1'b0;          // receiver: no stalls while set
    int hold_request = 0;             // receiver: one long stall, in cycles

    logic [7:0] resp_q[$];            // response under construction

    function automatic void clear_scan();
        scan     = '0;
        scan_pos = 8'd0;
    endfunction

    // Number parser for the second token: optional whitespace, one sign,
    // then digits; anything else stops it. Magnitude wraps at 16 bits.
    function automatic void feed_digit_token(input logic [7:0] c);
        logic is_digit;
        is_digit = (c >= mrc_pkg::CH_ZERO) && (c <= mrc_pkg::CH_NINE);
        unique case (scan.num_phase)
            mrc_pkg::NUM_SKIP: begin
                if (c == mrc_pkg::CH_TAB || c == mrc_pkg::CH_LF || c == mrc_pkg::CH_VT ||
                    c == mrc_pkg::CH_FF || c == mrc_pkg::CH_CR || c == mrc_pkg::CH_SPACE) begin
                    // leading whitespace is skipped
                end else if (c == mrc_pkg::CH_PLUS || c == mrc_pkg::CH_MINUS) begin
                    scan.num_negative = (c == mrc_pkg::CH_MINUS);
                    scan.num_phase    = mrc_pkg::NUM_DIGITS;
                end else if (is_digit) begin
                    scan.num_value = {8'd0, c - mrc_pkg::CH_ZERO};
                    scan.num_phase = mrc_pkg::NUM_DIGITS;
                end else begin
                    scan.num_phase = mrc_pkg::NUM_DONE;
                end
            end
            mrc_pkg::NUM_DIGITS: begin
                if (is_digit) begin
                    scan.num_value = scan.num_value * 16'd10 + {8'd0, c - mrc_pkg::CH_ZERO};
                end else begin
                    scan.num_phase = mrc_pkg::NUM_DONE;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void scan_byte(input logic [7:0] c);
        // past the byte limit, or after a NUL, the text is frozen
        if (scan.text_ended || scan_pos >= LIMIT_BYTES) begin
            return;
        end
        scanned_count++;
        if (c == mrc_pkg::CH_NUL) begin
            scan.text_ended = 1'b1;
            return;
        end
        if (scan_pos == 8'd0 && c == mrc_pkg::CH_CR) begin
            scan.starts_with_cr = 1'b1;
        end
        scan_pos++;

        // "OK" then CR
        if (scan.ok_prog == 2'd2 && c == mrc_pkg::CH_CR) begin
            scan.ok_seen = 1'b1;
            scan.ok_prog = 2'd0;
        end else if (c == mrc_pkg::CH_O) begin
            scan.ok_prog = 2'd1;
        end else if (scan.ok_prog == 2'd1 && c == mrc_pkg::CH_K) begin
            scan.ok_prog = 2'd2;
        end else begin
            scan.ok_prog = 2'd0;
        end

        // tag: all characters distinct, so a mismatch restarts on '+' only
        if (scan.tag_prog < mrc_pkg::TAG_LEN && c == TAG_TEXT[scan.tag_prog]) begin
            scan.tag_prog++;
            if (scan.tag_prog == mrc_pkg::TAG_LEN) begin
                scan.tag_seen = 1'b1;
                scan.tag_prog = 3'd0;
            end
        end else begin
            scan.tag_prog = (c == mrc_pkg::CH_PLUS) ? 3'd1 : 3'd0;
        end

        // tokens split on space and comma; only the second one is parsed
        if (c == mrc_pkg::CH_SPACE || c == mrc_pkg::CH_COMMA) begin
            scan.inside_token = 1'b0;
        end else begin
            if (!scan.inside_token) begin
                scan.inside_token = 1'b1;
                if (scan.token_index < mrc_pkg::TOK_MAX) begin
                    scan.token_index++;
                end
            end
            if (scan.token_index == mrc_pkg::TOK_NUM) begin
                feed_digit_token(c);
            end
        end
    endfunction

    function automatic mrc_pkg::t_result_code classify_response();
        logic [15:0] sbd_val;
        if (scan.starts_with_cr) begin
            return mrc_pkg::RES_EMPTY;
        end
        if (scan.ok_seen) begin
            return mrc_pkg::RES_OK;
        end
        if (scan.tag_seen) begin
            if (scan.token_index < mrc_pkg::TOK_NUM) begin
                return mrc_pkg::RES_NOT_SENT;   // no second token at all
            end
            sbd_val = scan.num_negative ? (16'd0 - scan.num_value) : scan.num_value;
            return (sbd_val <= 16'd2) ? mrc_pkg::RES_SENT : mrc_pkg::RES_NOT_SENT;
        end
        return mrc_pkg::RES_ERROR;
    endfunction

    // ------------------------------------------------------------------------
    // Monitor and checker. Both handshakes are sampled at the rising edge,
    // before any of this edge's nonblocking updates land. The byte side is
    // handled first so a response's expectation exists before its result.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        cycle_count++;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                bytes_sent++;
                scan_byte(i_rx_byte);
                if (i_last_byte) begin
                    pending_codes.push_back(classify_response());
                    clear_scan();
                    responses_sent++;
                end
            end
            if (o_out_valid && i_out_ready) begin
                results_seen++;
                if (pending_codes.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %0d",
                             $time, o_result_code);
                    err_count++;
                end else begin
                    want_code = pending_codes.pop_front();
                    code_tally[want_code]++;
                    if (o_result_code !== want_code) begin
                        $display("%0t: result_code mismatch, expected %0d (%s), actual %0d",
                                 $time, want_code, want_code.name(), o_result_code);
                        err_count++;
                    end
                end
            end
        end
    end

    // Run limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("%0t: run limit of %0d cycles reached", $time, CYCLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side: random stall per result, occasional stall-free runs, and
    // a long hold-off on request from the stimulus.
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int stall;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_request != 0) begin
                i_out_ready <= 1'b0;
                repeat (hold_request) @(posedge i_clk);
                hold_request = 0;
            end
            stall = rx_burst ? 0 : $urandom_range(0, 14);
            if ($urandom_range(0, 9) == 0) begin
                rx_burst = !rx_burst;
            end
            if (stall != 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && i_out_ready));
        end
    end

    // ------------------------------------------------------------------------
    // Byte side. send_byte leaves valid high after acceptance so the next
    // byte can follow in the very next cycle; park_input drops it.
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = in_burst ? 0 : $urandom_range(0, 14);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_rx_byte   <= b;
        i_last_byte <= last;
        i_in_valid  <= 1'b1;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
    endtask

    task automatic send_response();
        for (int i = 0; i < resp_q.size(); i++) begin
            send_byte(resp_q[i], i == resp_q.size() - 1);
        end
        resp_q.delete();
    endtask

    task automatic park_input();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Sender pause: nothing goes out until every queued result is back
    task automatic wait_results_drained();
        park_input();
        while (pending_codes.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Response builders
    // ------------------------------------------------------------------------
    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            resp_q.push_back(s[i]);
        end
    endtask

    task automatic add_noise(input int n, input bit allow_nul);
        repeat (n) resp_q.push_back(8'($urandom_range(allow_nul ? 0 : 1, 255)));
    endtask

    // lower-case filler never touches either matcher or the separators
    task automatic add_letters(input int n);
        repeat (n) resp_q.push_back(8'($urandom_range(8'h61, 8'h7A)));
    endtask

    task automatic add_number();
        int          pick;
        int unsigned val;
        logic [7:0]  blanks[6];
        blanks = '{mrc_pkg::CH_TAB, mrc_pkg::CH_LF, mrc_pkg::CH_VT,
                   mrc_pkg::CH_FF, mrc_pkg::CH_CR, mrc_pkg::CH_TAB};
        repeat ($urandom_range(0, 2)) resp_q.push_back(blanks[$urandom_range(0, 5)]);
        pick = $urandom_range(0, 5);
        if (pick == 0) resp_q.push_back(mrc_pkg::CH_PLUS);
        if (pick == 1) resp_q.push_back(mrc_pkg::CH_MINUS);
        if ($urandom_range(0, 5) == 0) add_text("00");
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: val = $urandom_range(0, 3);
            5:             val = $urandom_range(0, 99);
            6:             val = $urandom_range(65530, 65540);   // around the wrap
            7:             val = $urandom_range(0, 999999);
            8:             val = 131072 + $urandom_range(0, 3);  // wraps to 0..3
            default:       val = 32'hFFFF_FFFF;                  // no digits
        endcase
        if (val != 32'hFFFF_FFFF) begin
            add_text($sformatf("%0d", val));
        end
        if ($urandom_range(0, 3) == 0) add_noise(1, 1'b0);
    endtask

    task automatic build_sbdix_reply();
        case ($urandom_range(0, 3))
            0: ;
            1: begin
                add_text("AT+SBDIX");
                resp_q.push_back(mrc_pkg::CH_CR);
                resp_q.push_back(mrc_pkg::CH_CR);
                resp_q.push_back(mrc_pkg::CH_LF);
            end
            2: add_noise($urandom_range(1, 5), 1'b0);
            default: add_text("+SB");   // broken tag restarts on the next '+'
        endcase
        add_text(TAG_TEXT);
        repeat ($urandom_range(0, 2)) begin
            resp_q.push_back($urandom_range(0, 1) ? mrc_pkg::CH_SPACE : mrc_pkg::CH_COMMA);
        end
        if ($urandom_range(0, 7) != 0) add_number();
        if ($urandom_range(0, 1)) begin
            add_text(", ");
            add_number();
            add_text(", 0");
            resp_q.push_back(mrc_pkg::CH_CR);
            resp_q.push_back(mrc_pkg::CH_LF);
        end
        if ($urandom_range(0, 7) == 0) begin
            add_text("OK");
            resp_q.push_back(mrc_pkg::CH_CR);
        end
    endtask

    task automatic build_ok_reply();
        if ($urandom_range(0, 1)) add_noise($urandom_range(1, 6), 1'b0);
        if ($urandom_range(0, 1)) begin
            add_text("AT");
            resp_q.push_back(mrc_pkg::CH_CR);
        end
        add_text("OK");
        resp_q.push_back(mrc_pkg::CH_CR);
        if ($urandom_range(0, 1)) resp_q.push_back(mrc_pkg::CH_LF);
    endtask

    task automatic build_broken_reply();
        case ($urandom_range(0, 5))
            0: add_text("OK");
            1: begin
                add_text("O K");
                resp_q.push_back(mrc_pkg::CH_CR);
            end
            2: add_text("+SBDI+SBDX: 1");
            3: begin
                add_text("+SBDIX 0");
                resp_q.push_back(mrc_pkg::CH_CR);
            end
            4: begin
                add_text("OOK");
                resp_q.push_back(mrc_pkg::CH_CR);
            end
            default: begin
                add_text("OKK");
                resp_q.push_back(mrc_pkg::CH_CR);
                add_text("+SBDIX:,, ");
            end
        endcase
        if ($urandom_range(0, 1)) add_noise($urandom_range(1, 4), 1'b1);
    endtask

    // text cut short by a NUL; whatever follows must not count
    task automatic build_nul_cut_reply();
        case ($urandom_range(0, 3))
            0: begin
                add_text("OK");
                resp_q.push_back(mrc_pkg::CH_NUL);
                resp_q.push_back(mrc_pkg::CH_CR);
            end
            1: begin
                add_text("+SBDIX: 1");
                resp_q.push_back(mrc_pkg::CH_NUL);
                add_text("5, 0");
            end
            2: begin
                resp_q.push_back(mrc_pkg::CH_NUL);
                resp_q.push_back(mrc_pkg::CH_CR);
                add_text("OK");
                resp_q.push_back(mrc_pkg::CH_CR);
            end
            default: begin
                add_noise($urandom_range(0, 6), 1'b0);
                resp_q.push_back(mrc_pkg::CH_NUL);
                add_noise($urandom_range(0, 6), 1'b1);
            end
        endcase
        if ($urandom_range(0, 2) == 0) resp_q.push_back(mrc_pkg::CH_NUL);  // NUL as last byte
    endtask

    task automatic build_random_reply();
        case ($urandom_range(0, 15))
            0, 1, 2, 3, 4, 5, 6: build_sbdix_reply();
            7, 8, 9:             build_ok_reply();
            10: begin
                resp_q.push_back(mrc_pkg::CH_CR);
                add_noise($urandom_range(0, 8), 1'b1);
            end
            11, 12:              add_noise($urandom_range(1, 24), 1'b1);
            13, 14:              build_broken_reply();
            default:             build_nul_cut_reply();
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // One short response per code, plus the byte extremes as whole responses
    task automatic test_basic_codes();
        resp_q.push_back(mrc_pkg::CH_CR);              // empty
        send_response();
        add_text("OK");                                // ok
        resp_q.push_back(mrc_pkg::CH_CR);
        send_response();
        resp_q.push_back(mrc_pkg::CH_CR);              // leading CR beats OK
        add_text("OK");
        resp_q.push_back(mrc_pkg::CH_CR);
        send_response();
        add_text(TAG_TEXT);                            // tag, no second token
        send_response();
        add_text("+SBDIX:,2");                         // sent
        send_response();
        resp_q.push_back(mrc_pkg::CH_NUL);             // lone NUL: nothing counted
        send_response();
        resp_q.push_back(8'hFF);                       // top byte value
        send_response();
        wait_results_drained();
    endtask

    // Matches that straddle or sit beyond the byte limit
    task automatic test_byte_limit();
        add_letters(LIMIT_BYTES - 2);                  // CR lands past the limit
        add_text("OK");
        resp_q.push_back(mrc_pkg::CH_CR);
        send_response();
        add_letters(LIMIT_BYTES - 3);                  // CR is the last counted byte
        add_text("OK");
        resp_q.push_back(mrc_pkg::CH_CR);
        send_response();
        add_letters(LIMIT_BYTES - 9);                  // "12" cut to "1"
        add_text("+SBDIX: 12");
        send_response();
        add_letters(LIMIT_BYTES + $urandom_range(0, 10));
        add_text("+SBDIX: 1");
        send_response();
        add_letters(LIMIT_BYTES);                      // NUL final past the limit
        resp_q.push_back(mrc_pkg::CH_NUL);
        send_response();
        wait_results_drained();
    endtask

    task automatic test_nul_in_text();
        repeat (12) begin
            build_nul_cut_reply();
            send_response();
        end
        wait_results_drained();
    endtask

    // Bulk random traffic, mostly well-formed replies with random content
    task automatic test_random_traffic();
        int stop_at;
        stop_at = bytes_sent + 400;
        while (bytes_sent < stop_at) begin
            if ($urandom_range(0, 5) == 0) in_burst = !in_burst;
            build_random_reply();
            send_response();
        end
        in_burst = 1'b0;
        wait_results_drained();
    endtask

    // Result side holds off while bytes keep coming back to back, so the
    // block backs up and stalls the byte channel on a final byte.
    task automatic test_output_backpressure();
        hold_request = 250;
        in_burst     = 1'b1;
        repeat (12) begin
            case ($urandom_range(0, 2))
                0:       build_ok_reply();
                1:       resp_q.push_back(mrc_pkg::CH_CR);
                default: build_sbdix_reply();
            endcase
            send_response();
        end
        in_burst = 1'b0;
        wait_results_drained();
    endtask

    // One response at a time, each fully drained before the next
    task automatic test_paced_responses();
        repeat (20) begin
            build_random_reply();
            send_response();
            wait_results_drained();
        end
    endtask

    initial begin
        clear_scan();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_basic_codes();
        test_byte_limit();
        test_nul_in_text();
        test_random_traffic();
        test_output_backpressure();
        test_paced_responses();

        // catch any stray result after the last one expected
        wait_results_drained();
        repeat (10) @(posedge i_clk);

        $display("Run: %0d responses, %0d bytes (%0d scanned), %0d results checked",
                 responses_sent, bytes_sent, scanned_count, results_seen);
        $display("Codes: empty %0d, ok %0d, sent %0d, not sent %0d, error %0d",
                 code_tally[mrc_pkg::RES_EMPTY], code_tally[mrc_pkg::RES_OK],
                 code_tally[mrc_pkg::RES_SENT], code_tally[mrc_pkg::RES_NOT_SENT],
                 code_tally[mrc_pkg::RES_ERROR]);
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
